### hw/rtl/dlsq_pkg.sv
// Shared types and constants for the delta-list sleep queue.
package dlsq_pkg;

    typedef enum logic [1:0] {
        EV_INSERTED = 2'd0,
        EV_FULL     = 2'd1,
        EV_ZERO     = 2'd2,
        EV_WOKEN    = 2'd3
    } event_t;

    localparam int MAX_RESULTS = 16;
    localparam int REL_W       = $clog2(MAX_RESULTS + 1);

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_TICK   = 1'b1;

endpackage

### hw/rtl/delta_list_sleep_queue_top.sv
// Delta-list sleep queue: one ring memory of task ids and relative waits with a sequencer.
//
// The queue sits in a single synchronous memory used as a ring, so waking the head only moves
// a pointer. One item is handled at a time. An insert walks the list, one memory read per
// passed entry, then moves every later entry up one place (a read and a write each), then
// writes the new entry. A tick decrements the head wait and stops there when nothing wakes;
// else it releases each woken task in turn, reading the next head unless the queue has emptied
// or the per-tick limit is reached; a result also waits while its output stalls.
module delta_list_sleep_queue_top #(
    parameter int CAPACITY    = 16,
    parameter int DELTA_WIDTH = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic                    mode,
    input  logic [7:0]              task_id,
    input  logic [15:0]             sleep_time,
    output logic                    out_valid,
    input  logic                    out_stall,
    output dlsq_pkg::event_t        event_res,
    output logic [7:0]              task_id_out,
    output logic                    last
);
    import dlsq_pkg::*;

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [32:0] DMAX = (33'd1 << DELTA_WIDTH) - 33'd1;

    typedef enum logic [10:0] {
        S_IDLE = 11'b00000000001,
        S_WRD  = 11'b00000000010,
        S_WCHK = 11'b00000000100,
        S_SRD  = 11'b00000001000,
        S_SWR  = 11'b00000010000,
        S_INS  = 11'b00000100000,
        S_TCHK = 11'b00001000000,
        S_REL  = 11'b00010000000,
        S_NRD  = 11'b00100000000,
        S_NCHK = 11'b01000000000,
        S_EMIT = 11'b10000000000
    } state_t;

    logic [7:0]             mem_task  [CAPACITY];
    logic [DELTA_WIDTH-1:0] mem_delta [CAPACITY];

    state_t                 state_reg, state_next;
    logic [IW-1:0]          head_reg, head_next;
    logic [CW-1:0]          count_reg, count_next;
    logic [CW-1:0]          pos_reg, pos_next;
    logic [CW-1:0]          j_reg, j_next;
    logic [DELTA_WIDTH-1:0] rem_reg, rem_next;
    logic [REL_W-1:0]       rel_reg, rel_next;
    logic [7:0]             tid_reg, tid_next;
    logic [7:0]             cur_task_reg, cur_task_next;
    event_t                 pend_ev_reg, pend_ev_next;
    logic [7:0]             pend_tid_reg, pend_tid_next;
    logic                   pend_last_reg, pend_last_next;
    logic                   cont_reg, cont_next;
    logic                   out_valid_reg, out_valid_next;
    event_t                 out_ev_reg, out_ev_next;
    logic [7:0]             out_tid_reg, out_tid_next;
    logic                   out_last_reg, out_last_next;

    logic                   rd_en, wr_en;
    logic [IW-1:0]          rd_addr, wr_addr;
    logic [7:0]             wr_task;
    logic [DELTA_WIDTH-1:0] wr_delta;
    logic [7:0]             rd_task_reg;
    logic [DELTA_WIDTH-1:0] rd_delta_reg;

    logic [32:0]            st_ext;
    logic [DELTA_WIDTH-1:0] st_sat;
    logic [DELTA_WIDTH-1:0] dec_delta;
    logic [CW-1:0]          jm1;

    function automatic logic [IW-1:0] phys(input logic [IW-1:0] h, input logic [CW-1:0] l);
        logic [CW:0] s;
        s = CW'(h) + (CW+1)'(l);
        if (s >= (CW+1)'(CAPACITY))
            s = s - (CW+1)'(CAPACITY);
        return s[IW-1:0];
    endfunction

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_task[wr_addr]  <= wr_task;
            mem_delta[wr_addr] <= wr_delta;
        end
        if (rd_en)
        begin
            rd_task_reg  <= mem_task[rd_addr];
            rd_delta_reg <= mem_delta[rd_addr];
        end
    end

    assign st_ext    = 33'(sleep_time);
    assign st_sat    = (st_ext > DMAX) ? DMAX[DELTA_WIDTH-1:0] : st_ext[DELTA_WIDTH-1:0];
    assign dec_delta = (rd_delta_reg != '0) ? rd_delta_reg - 1'b1 : '0;
    assign jm1       = j_reg - 1'b1;

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        pos_next       = pos_reg;
        j_next         = j_reg;
        rem_next       = rem_reg;
        rel_next       = rel_reg;
        tid_next       = tid_reg;
        cur_task_next  = cur_task_reg;
        pend_ev_next   = pend_ev_reg;
        pend_tid_next  = pend_tid_reg;
        pend_last_next = pend_last_reg;
        cont_next      = cont_reg;
        out_valid_next = out_valid_reg;
        out_ev_next    = out_ev_reg;
        out_tid_next   = out_tid_reg;
        out_last_next  = out_last_reg;
        rd_en          = 1'b0;
        rd_addr        = head_reg;
        wr_en          = 1'b0;
        wr_addr        = head_reg;
        wr_task        = rd_task_reg;
        wr_delta       = rd_delta_reg;

        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (mode == MODE_INSERT)
                    begin
                        tid_next       = task_id;
                        pend_tid_next  = task_id;
                        pend_last_next = 1'b1;
                        cont_next      = 1'b0;
                        if (sleep_time == '0)
                        begin
                            pend_ev_next = EV_ZERO;
                            state_next   = S_EMIT;
                        end
                        else if (count_reg == CW'(CAPACITY))
                        begin
                            pend_ev_next = EV_FULL;
                            state_next   = S_EMIT;
                        end
                        else
                        begin
                            rem_next   = st_sat;
                            pos_next   = '0;
                            state_next = S_WRD;
                        end
                    end
                    else if (count_reg != '0)
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = head_reg;
                        rel_next   = '0;
                        state_next = S_TCHK;
                    end
                end
            end
            S_WRD:
            begin
                if (pos_reg < count_reg)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = phys(head_reg, pos_reg);
                    state_next = S_WCHK;
                end
                else
                    state_next = S_INS;
            end
            S_WCHK:
            begin
                if (rem_reg >= rd_delta_reg)
                begin
                    rem_next   = rem_reg - rd_delta_reg;
                    pos_next   = pos_reg + 1'b1;
                    state_next = S_WRD;
                end
                else
                begin
                    j_next     = count_reg;
                    state_next = S_SRD;
                end
            end
            S_SRD:
            begin
                rd_en      = 1'b1;
                rd_addr    = phys(head_reg, jm1);
                state_next = S_SWR;
            end
            S_SWR:
            begin
                wr_en   = 1'b1;
                wr_addr = phys(head_reg, j_reg);
                if (jm1 == pos_reg)
                begin
                    wr_delta   = rd_delta_reg - rem_reg;
                    state_next = S_INS;
                end
                else
                    state_next = S_SRD;
                j_next = jm1;
            end
            S_INS:
            begin
                wr_en          = 1'b1;
                wr_addr        = phys(head_reg, pos_reg);
                wr_task        = tid_reg;
                wr_delta       = rem_reg;
                count_next     = count_reg + 1'b1;
                pend_ev_next   = EV_INSERTED;
                pend_tid_next  = tid_reg;
                pend_last_next = 1'b1;
                cont_next      = 1'b0;
                state_next     = S_EMIT;
            end
            S_TCHK:
            begin
                wr_en    = 1'b1;
                wr_addr  = head_reg;
                wr_delta = dec_delta;
                if (dec_delta == '0)
                begin
                    cur_task_next = rd_task_reg;
                    state_next    = S_REL;
                end
                else
                    state_next = S_IDLE;
            end
            S_REL:
            begin
                pend_ev_next  = EV_WOKEN;
                pend_tid_next = cur_task_reg;
                head_next     = phys(head_reg, CW'(1));
                count_next    = count_reg - 1'b1;
                rel_next      = rel_reg + 1'b1;
                if (count_reg == CW'(1) || rel_reg == REL_W'(MAX_RESULTS - 1))
                begin
                    pend_last_next = 1'b1;
                    cont_next      = 1'b0;
                    state_next     = S_EMIT;
                end
                else
                    state_next = S_NRD;
            end
            S_NRD:
            begin
                rd_en      = 1'b1;
                rd_addr    = head_reg;
                state_next = S_NCHK;
            end
            S_NCHK:
            begin
                if (rd_delta_reg == '0)
                begin
                    pend_last_next = 1'b0;
                    cont_next      = 1'b1;
                    cur_task_next  = rd_task_reg;
                end
                else
                begin
                    pend_last_next = 1'b1;
                    cont_next      = 1'b0;
                end
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_ev_next    = pend_ev_reg;
                    out_tid_next   = pend_tid_reg;
                    out_last_next  = pend_last_reg;
                    state_next     = cont_reg ? S_REL : S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            cont_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            cont_reg      <= cont_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg       <= pos_next;
        j_reg         <= j_next;
        rem_reg       <= rem_next;
        rel_reg       <= rel_next;
        tid_reg       <= tid_next;
        cur_task_reg  <= cur_task_next;
        pend_ev_reg   <= pend_ev_next;
        pend_tid_reg  <= pend_tid_next;
        pend_last_reg <= pend_last_next;
        out_ev_reg    <= out_ev_next;
        out_tid_reg   <= out_tid_next;
        out_last_reg  <= out_last_next;
    end

    assign in_stall    = (state_reg != S_IDLE);
    assign out_valid   = out_valid_reg;
    assign event_res   = out_ev_reg;
    assign task_id_out = out_tid_reg;
    assign last        = out_last_reg;

endmodule

### sim/delta_list_sleep_queue_top_tb.sv
// Self-checking testbench for the delta-list sleep queue: directed table, then random traffic.
module delta_list_sleep_queue_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import dlsq_pkg::*;

    localparam int CAP = 16;
    localparam int N_RANDOM = 440;

    typedef struct packed {
        event_t     ev;
        logic [7:0] tid;
        logic       fin;
    } wake_rec_t;

    typedef struct {
        logic        md;
        logic [7:0]  tid;
        logic [15:0] st;
        logic        known;
        event_t      ev;
    } row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        mode = MODE_INSERT;
    logic [7:0]  task_id = '0;
    logic [15:0] sleep_time = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    event_t      event_res;
    logic [7:0]  task_id_out;
    logic        last;

    logic [7:0]  q_task [CAP];
    logic [15:0] q_delta [CAP];
    int          q_len;
    wake_rec_t   pending_q [$];
    int          errors = 0;
    bit          stim_done = 1'b0;

    delta_list_sleep_queue_top #(.CAPACITY(CAP), .DELTA_WIDTH(16)) uut (.*);

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic void predict_queue(logic md, logic [7:0] tid, logic [15:0] st);
        int pos;
        int rel;
        logic [15:0] t;
        pos = 0;
        rel = 0;
        t = st;
        if (md == MODE_INSERT)
        begin
            if (st == 0)
                pending_q.push_back('{EV_ZERO, tid, 1'b1});
            else if (q_len >= CAP)
                pending_q.push_back('{EV_FULL, tid, 1'b1});
            else
            begin
                while (pos < q_len && t >= q_delta[pos])
                begin
                    t -= q_delta[pos];
                    pos++;
                end
                for (int j = q_len; j > pos; j--)
                begin
                    q_task[j] = q_task[j-1];
                    q_delta[j] = q_delta[j-1];
                end
                q_task[pos] = tid;
                q_delta[pos] = t;
                q_len++;
                if (pos + 1 < q_len)
                    q_delta[pos+1] -= t;
                pending_q.push_back('{EV_INSERTED, tid, 1'b1});
            end
        end
        else if (q_len > 0)
        begin
            if (q_delta[0] > 0)
                q_delta[0]--;
            while (rel < q_len && rel < MAX_RESULTS && q_delta[rel] == 0)
            begin
                pending_q.push_back('{EV_WOKEN, q_task[rel], 1'b0});
                rel++;
            end
            if (rel > 0)
            begin
                for (int j = rel; j < q_len; j++)
                begin
                    q_task[j-rel] = q_task[j];
                    q_delta[j-rel] = q_delta[j];
                end
                q_len -= rel;
                pending_q[$].fin = 1'b1;
            end
        end
    endfunction

    task automatic send_item(logic md, logic [7:0] tid, logic [15:0] st);
        @(negedge clk);
        if ($urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        mode <= md;
        task_id <= tid;
        sleep_time <= st;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        predict_queue(md, tid, st);
    endtask

    task automatic drain_results;
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_q.size() != 0) @(negedge clk);
    endtask

    initial
    begin
        row_t rows [$];
        int burst;
        logic [15:0] st;
        q_len = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        rows.push_back('{MODE_TICK,   8'h00, 16'h0000, 1'b0, EV_WOKEN});
        rows.push_back('{MODE_INSERT, 8'hFF, 16'h0000, 1'b1, EV_ZERO});
        rows.push_back('{MODE_INSERT, 8'h00, 16'h0001, 1'b1, EV_INSERTED});
        rows.push_back('{MODE_INSERT, 8'hA5, 16'hFFFF, 1'b1, EV_INSERTED});
        rows.push_back('{MODE_INSERT, 8'h5A, 16'h0001, 1'b1, EV_INSERTED});
        rows.push_back('{MODE_INSERT, 8'h11, 16'h0003, 1'b1, EV_INSERTED});
        rows.push_back('{MODE_TICK,   8'hFF, 16'hFFFF, 1'b0, EV_WOKEN});
        rows.push_back('{MODE_TICK,   8'h00, 16'h0000, 1'b0, EV_WOKEN});
        for (int i = 0; i < 14; i++)
            rows.push_back('{MODE_INSERT, 8'(8'h20 + i), 16'(5 + (i % 3)), 1'b0, EV_INSERTED});
        rows.push_back('{MODE_INSERT, 8'h77, 16'h0002, 1'b1, EV_FULL});
        rows.push_back('{MODE_INSERT, 8'h78, 16'h0000, 1'b1, EV_ZERO});
        for (int i = 0; i < 3; i++)
            rows.push_back('{MODE_TICK, 8'h00, 16'h0000, 1'b0, EV_WOKEN});

        foreach (rows[i])
        begin
            send_item(rows[i].md, rows[i].tid, rows[i].st);
            if (rows[i].known && pending_q[$].ev != rows[i].ev)
            begin
                errors++;
                if (errors <= 10)
                    $display("row %0d: status expected %0d, table %0d", i,
                             pending_q[$].ev, rows[i].ev);
            end
        end
        drain_results();
        for (int i = 0; i < 5; i++)
            send_item(MODE_TICK, 8'h00, 16'h0000);

        for (int n = 0; n < N_RANDOM; n += burst)
        begin
            burst = $urandom_range(1, 12);
            for (int b = 0; b < burst; b++)
            begin
                if ($urandom_range(0, 99) < 45)
                    send_item(MODE_TICK, 8'($urandom), 16'($urandom));
                else
                begin
                    case ($urandom_range(0, 9))
                        0: st = 16'd0;
                        1: st = 16'($urandom);
                        2: st = 16'hFFFF;
                        default: st = 16'($urandom_range(1, 12));
                    endcase
                    send_item(MODE_INSERT, 8'($urandom), st);
                end
            end
            @(negedge clk);
            in_valid <= 1'b0;
            repeat ($urandom_range(0, 8)) @(negedge clk);
            if (n == 200)
                drain_results();
        end
        drain_results();
        repeat (60) @(posedge clk);
        stim_done = 1'b1;
    end

    initial
    begin
        forever
        begin
            repeat ($urandom_range(10, 40)) @(negedge clk) out_stall <= 1'b0;
            repeat ($urandom_range(1, 30)) @(negedge clk) out_stall <= ($urandom_range(0, 2) != 0);
        end
    end

    always @(posedge clk)
    begin
        wake_rec_t exp_r;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected transfer: ev %0d id %0d last %0d",
                             event_res, task_id_out, last);
            end
            else
            begin
                exp_r = pending_q.pop_front();
                if (exp_r.ev !== event_res || exp_r.tid !== task_id_out || exp_r.fin !== last)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: expected ev %0d id %0d last %0d, got %0d %0d %0d",
                                 exp_r.ev, exp_r.tid, exp_r.fin,
                                 event_res, task_id_out, last);
                end
            end
        end
    end

    initial
    begin
        wait (stim_done);
        if (errors == 0 && pending_q.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Some tests failed");
        $finish;
    end
endmodule

### delta_list_sleep_queue_top.f
hw/rtl/dlsq_pkg.sv
hw/rtl/delta_list_sleep_queue_top.sv
sim/delta_list_sleep_queue_top_tb.sv
